// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// depends on: a clk and an arst_n signal in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, held off while reset is asserted
`define GMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property checked at every rising edge, reset included
`define GMS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/gms_pkg.sv
// types and constants of the grid map cell store
// depends on: nothing
package gms_pkg;

	// field widths
	localparam int SZ_W = 17;
	localparam int COORD_W = 16;
	localparam int VAL_W = 8;
	localparam int OP_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int IN_TDATA_W = 64;
	localparam int OUT_TDATA_W = 16;

	// input tdata bit positions
	localparam int IN_OP_LSB = 0;
	localparam int IN_CX_LSB = IN_OP_LSB + OP_W;
	localparam int IN_CY_LSB = IN_CX_LSB + COORD_W;
	localparam int IN_CZ_LSB = IN_CY_LSB + COORD_W;
	localparam int IN_VAL_LSB = IN_CZ_LSB + COORD_W;

	// output tdata bit positions
	localparam int OUT_STATUS_BIT = 0;
	localparam int OUT_RD_LSB = 1;
	localparam int OUT_EQ_BIT = OUT_RD_LSB + VAL_W;

	// size register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
	localparam logic [SZ_W-1:0] SIZE_X_RST = 17'd256;
	localparam logic [SZ_W-1:0] SIZE_Y_RST = 17'd256;
	localparam logic [SZ_W-1:0] SIZE_Z_RST = 17'd1;

	// operation codes; the spare code acts as a read
	typedef enum logic [OP_W-1:0] {
		OP_READ    = 2'd0,
		OP_WRITE   = 2'd1,
		OP_COMPARE = 2'd2
	} op_t;

	// one request as taken from the stream
	typedef struct packed {
		op_t                        op;
		logic signed [COORD_W-1:0]  cx;
		logic signed [COORD_W-1:0]  cy;
		logic signed [COORD_W-1:0]  cz;
		logic [VAL_W-1:0]           val;
	} req_t;

	// request at the cell access stage
	typedef struct packed {
		logic              valid;
		logic              in_range;
		op_t               op;
		logic [VAL_W-1:0]  val;
	} acc_t;

endpackage

// File: hw/rtl/gms_index.sv
// range check and linear index pipeline of the grid map cell store
// depends on: gms_pkg
module gms_index #(
	parameter int CAPACITY = 65536,
	parameter int NUM_AXES = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  gms_pkg::req_t                    req,
	input  logic [gms_pkg::SZ_W-1:0]         size_x,
	input  logic [gms_pkg::SZ_W-1:0]         size_y,
	input  logic [gms_pkg::SZ_W-1:0]         size_z,
	output gms_pkg::acc_t                    acc,
	output logic [$clog2(CAPACITY)-1:0]      idx
);
	import gms_pkg::*;

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CAP_W = $clog2(CAPACITY + 1);
	localparam logic [2*SZ_W-1:0] CAP_XY = (2*SZ_W)'(CAPACITY);
	localparam logic [CAP_W+SZ_W-1:0] CAP_T = (CAP_W+SZ_W)'(CAPACITY);

	// stage 2 signals
	logic [COORD_W-1:0] cx_u, cy_u, cz_u;
	logic ok_x, ok_y, ok_z;
	logic [2*SZ_W-1:0] xy_prod;
	logic [COORD_W+SZ_W-1:0] y_prod;
	logic v_s2, ok_s2, sxy_big_s2;
	op_t op_s2;
	logic [VAL_W-1:0] val_s2;
	logic [ADDR_W-1:0] x_s2, yoff_s2;
	logic [COORD_W-1:0] cz_s2;
	logic [CAP_W-1:0] sxy_s2;

	// stage 3 signals
	logic [COORD_W+CAP_W-1:0] z_prod;
	logic [SZ_W-1:0] sz_eff;
	logic [CAP_W+SZ_W-1:0] t_prod;
	logic v_s3, ok_s3, tbig_s3;
	op_t op_s3;
	logic [VAL_W-1:0] val_s3;
	logic [ADDR_W-1:0] xy_s3, zoff_s3;

	// stage 4 signals
	logic v_s4, in_range_s4;
	op_t op_s4;
	logic [VAL_W-1:0] val_s4;
	logic [ADDR_W-1:0] idx_s4;

	// per-axis checks, y stride product and xy plane size
	always_comb begin
		cx_u = $unsigned(req.cx);
		cy_u = $unsigned(req.cy);
		cz_u = $unsigned(req.cz);
		ok_x = !req.cx[COORD_W-1] && (SZ_W'(cx_u) < size_x);
		ok_y = !req.cy[COORD_W-1] && (SZ_W'(cy_u) < size_y);
		ok_z = (NUM_AXES >= 3) ? (!req.cz[COORD_W-1] && (SZ_W'(cz_u) < size_z)) : 1'b1;
		xy_prod = size_x * size_y;
		y_prod = cy_u * size_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2 <= req.op;
			val_s2 <= req.val;
			ok_s2 <= ok_x && ok_y && ok_z;
			x_s2 <= ADDR_W'(cx_u);
			yoff_s2 <= y_prod[ADDR_W-1:0];
			cz_s2 <= cz_u;
			sxy_s2 <= xy_prod[CAP_W-1:0];
			sxy_big_s2 <= (xy_prod > CAP_XY);
		end
	end

	// z stride product, total size and partial index
	always_comb begin
		sz_eff = (NUM_AXES >= 3) ? size_z : SZ_W'(1);
		z_prod = cz_s2 * sxy_s2;
		t_prod = sxy_s2 * sz_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3 <= op_s2;
			val_s3 <= val_s2;
			ok_s3 <= ok_s2 && !sxy_big_s2;
			tbig_s3 <= (t_prod > CAP_T);
			xy_s3 <= x_s2 + yoff_s2;
			zoff_s3 <= (NUM_AXES >= 3) ? z_prod[ADDR_W-1:0] : '0;
		end
	end

	// final index and range verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4 <= op_s3;
			val_s4 <= val_s3;
			in_range_s4 <= ok_s3 && !tbig_s3;
			idx_s4 <= xy_s3 + zoff_s3;
		end
	end

	assign acc = '{valid: v_s4, in_range: in_range_s4, op: op_s4, val: val_s4};
	assign idx = idx_s4;

endmodule

// File: hw/rtl/gms_ram.sv
// single port cell memory with registered read, read before write
// depends on: nothing
module gms_ram #(
	parameter int DEPTH = 65536,
	parameter int DATA_W = 8
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic                        re,
	input  logic [$clog2(DEPTH)-1:0]    addr,
	input  logic [DATA_W-1:0]           wdata,
	output logic [DATA_W-1:0]           rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: hw/rtl/grid_map_cell_store_top.sv
// grid map cell store: top level with size registers, clear sweep and result stage
// depends on: gms_pkg, gms_index, gms_ram
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | s_tdata: op, coord_x, coord_y, coord_z, cell_value
//  m_*      | out | m_tvalid/m_tready  | m_tdata: status, read_value, equal
//  cfg_*    | in  | cfg_we             | cfg_index selects size_x/size_y/size_z, cfg_data
//
// one request per cycle while no result is held and the clear sweep is over; m_tvalid rises
// once a request has passed the input register, two multiply stages, index add, memory read
// and result register; after reset a sweep writes zero to every cell with s_tready low
// the whole pipeline holds while a result waits and m_tready is low
module grid_map_cell_store_top #(
	parameter int CAPACITY = 65536,
	parameter int CELL_WIDTH = 8,
	parameter int NUM_AXES = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// op[1:0], coord_x[17:2], coord_y[33:18], coord_z[49:34], cell_value[57:50], zeros
	input  logic [gms_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// status[0], read_value[8:1], equal[9], zeros
	output logic [gms_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic [gms_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gms_pkg::SZ_W-1:0]            cfg_data
);
	import gms_pkg::*;

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CAPACITY - 1);

	logic [SZ_W-1:0] size_x_q, size_y_q, size_z_q;
	logic clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic adv;
	logic v_s1;
	req_t req_in, req_s1;
	acc_t acc;
	logic [ADDR_W-1:0] idx;
	logic ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [CELL_WIDTH-1:0] ram_wdata, ram_rdata;
	logic v_s5, in_range_s5;
	op_t op_s5;
	logic [VAL_W-1:0] val_s5;
	logic res_status, res_equal;
	logic [VAL_W-1:0] res_rd;
	logic out_valid_q, status_q, equal_q;
	logic [VAL_W-1:0] rd_q;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_X_RST;
			size_y_q <= SIZE_Y_RST;
			size_z_q <= SIZE_Z_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIZE_X: size_x_q <= cfg_data;
				REG_SIZE_Y: size_y_q <= cfg_data;
				REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clear sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// global advance: pipeline moves unless a result is stuck at the output
	assign adv = !out_valid_q || m_tready;
	assign s_tready = adv && !clr_busy_q;

	// input register
	always_comb begin
		req_in.op = op_t'(s_tdata[IN_OP_LSB +: OP_W]);
		req_in.cx = $signed(s_tdata[IN_CX_LSB +: COORD_W]);
		req_in.cy = $signed(s_tdata[IN_CY_LSB +: COORD_W]);
		req_in.cz = $signed(s_tdata[IN_CZ_LSB +: COORD_W]);
		req_in.val = s_tdata[IN_VAL_LSB +: VAL_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= req_in;
		end
	end

	// range check and index
	gms_index #(
		.CAPACITY (CAPACITY),
		.NUM_AXES (NUM_AXES)
	) u_index (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s1),
		.req      (req_s1),
		.size_x   (size_x_q),
		.size_y   (size_y_q),
		.size_z   (size_z_q),
		.acc      (acc),
		.idx      (idx)
	);

	// cell memory port, shared with the clear sweep
	always_comb begin
		if (clr_busy_q) begin
			ram_we = 1'b1;
			ram_addr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we = adv && acc.valid && acc.in_range && (acc.op == OP_WRITE);
			ram_addr = idx;
			ram_wdata = CELL_WIDTH'(acc.val);
		end
	end

	gms_ram #(
		.DEPTH  (CAPACITY),
		.DATA_W (CELL_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (adv),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// request alongside the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= acc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_range_s5 <= acc.in_range;
			op_s5 <= acc.op;
			val_s5 <= acc.val;
		end
	end

	// result fields
	always_comb begin
		res_status = !in_range_s5;
		res_rd = '0;
		res_equal = 1'b0;
		if (in_range_s5) begin
			case (op_s5)
				OP_WRITE: ;
				OP_COMPARE: begin
					res_rd = VAL_W'(ram_rdata);
					res_equal = (ram_rdata == CELL_WIDTH'(val_s5));
				end
				default: res_rd = VAL_W'(ram_rdata);
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= res_status;
			rd_q <= res_rd;
			equal_q <= res_equal;
		end
	end

	assign m_tvalid = out_valid_q;
	always_comb begin
		m_tdata = '0;
		m_tdata[OUT_STATUS_BIT] = status_q;
		m_tdata[OUT_RD_LSB +: VAL_W] = rd_q;
		m_tdata[OUT_EQ_BIT] = equal_q;
	end

endmodule

// File: hw/rtl/gms_checker.sv
// port level checks of the grid map cell store, bound to the top level
// depends on: gms_pkg, assert_macros.svh, grid_map_cell_store_top
`include "assert_macros.svh"

module gms_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [gms_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import gms_pkg::*;

	localparam logic [3:0] MAX_INFLIGHT = 4'd6;

	logic s_xfer, m_xfer;
	logic [3:0] cnt_q;
	logic res_oor, res_data_zero;

	assign s_xfer = s_tvalid && s_tready;
	assign m_xfer = m_tvalid && m_tready;

	// out of range flag and the data bits beside it
	assign res_oor = m_tdata[OUT_STATUS_BIT];
	assign res_data_zero = (m_tdata[OUT_EQ_BIT:OUT_RD_LSB] == '0);

	// requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + {3'd0, s_xfer} - {3'd0, m_xfer};
		end
	end

	`GMS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result moved")
	`GMS_ASSERT(a_no_orphan, m_xfer |-> cnt_q != 4'd0, "result transfer with none pending")
	`GMS_ASSERT(a_depth, cnt_q <= MAX_INFLIGHT, "more requests in flight than stages")
	`GMS_ASSERT(a_oor_clean, m_tvalid && res_oor |-> res_data_zero, "out of range carries data")
	`GMS_ASSERT(a_stall_in, m_tvalid && !m_tready |-> !s_tready, "input taken while held")

endmodule

bind grid_map_cell_store_top gms_checker u_gms_checker (.*);
